// ----- hdl/nchs_pkg.sv -----
// Shared types, constants and arithmetic helpers for the neighbor-cell spatial hash.
package nchs_pkg;

  localparam int CORNER_COUNT = 8;
  localparam int CORNER_W     = $clog2(CORNER_COUNT);
  localparam int POS_W        = 32;
  localparam int COORD_W      = 32;
  localparam int HASH_W       = 31;
  localparam int LOG2_W       = 5;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int FRONT_STAGES = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Corner offsets, bit i belongs to corner i of the fixed visiting order.
  localparam logic [CORNER_COUNT-1:0] CORNER_DX = 8'b0110_0110;
  localparam logic [CORNER_COUNT-1:0] CORNER_DY = 8'b1111_0000;
  localparam logic [CORNER_COUNT-1:0] CORNER_DZ = 8'b0011_1100;

  localparam logic [31:0] INV_CELL_RESET = 32'd65536;
  localparam logic [4:0]  LOG2_RESET     = 5'd16;
  localparam logic [31:0] PRIME_X_RESET  = 32'd73856093;
  localparam logic [31:0] PRIME_Y_RESET  = 32'd19349663;
  localparam logic [31:0] PRIME_Z_RESET  = 32'd83492791;

  typedef enum logic [2:0] {
    REG_INV_CELL = 3'd0,
    REG_LOG2     = 3'd1,
    REG_PRIME_X  = 3'd2,
    REG_PRIME_Y  = 3'd3,
    REG_PRIME_Z  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       inv_cell;
    logic [LOG2_W-1:0] log2;
    logic [31:0]       prime_x;
    logic [31:0]       prime_y;
    logic [31:0]       prime_z;
  } cfg_t;

  typedef struct packed {
    logic [CORNER_COUNT-1:0][HASH_W-1:0] hash;
    logic [CORNER_COUNT-1:0]             keep;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Exact signed Q16.16 times unsigned Q16.16, kept modulo 2^64 as Q32.32.
  function automatic logic [63:0] scale_pos(input logic [POS_W-1:0] pos,
                                            input logic [31:0] inv);
    logic signed [64:0] p;
    p = $signed({pos[POS_W-1], pos}) * $signed({1'b0, inv});
    return p[63:0];
  endfunction

  // Subtract half a cell and keep the integer part, floored.
  function automatic logic [COORD_W-1:0] floor_coord(input logic [63:0] prod);
    return prod[63:32] - {31'd0, ~prod[31]};
  endfunction

endpackage

// ----- hdl/nchs_in_if.sv -----
// Input channel: one point per word.
interface nchs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ----- hdl/nchs_out_if.sv -----
// Result channel: one distinct cell hash per word.
interface nchs_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] cell_hash;
  logic        is_last;

  modport source (output valid, output cell_hash, output is_last, input ready);
  modport sink   (input valid, input cell_hash, input is_last, output ready);
endinterface

// ----- hdl/nchs_cfg.sv -----
// Configuration register file behind the APB-style port.
module nchs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nchs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nchs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nchs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output nchs_pkg::cfg_t                 cfg
);
  import nchs_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_INV_CELL: cfg_nxt.inv_cell = pwdata;
        REG_LOG2:     cfg_nxt.log2     = pwdata[LOG2_W-1:0];
        REG_PRIME_X:  cfg_nxt.prime_x  = pwdata;
        REG_PRIME_Y:  cfg_nxt.prime_y  = pwdata;
        REG_PRIME_Z:  cfg_nxt.prime_z  = pwdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INV_CELL: prdata = cfg_r.inv_cell;
      REG_LOG2:     prdata = {{(CFG_DATA_W-LOG2_W){1'b0}}, cfg_r.log2};
      REG_PRIME_X:  prdata = cfg_r.prime_x;
      REG_PRIME_Y:  prdata = cfg_r.prime_y;
      REG_PRIME_Z:  prdata = cfg_r.prime_z;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_cell <= INV_CELL_RESET;
      cfg_r.log2     <= LOG2_RESET;
      cfg_r.prime_x  <= PRIME_X_RESET;
      cfg_r.prime_y  <= PRIME_Y_RESET;
      cfg_r.prime_z  <= PRIME_Z_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/nchs_front.sv -----
// Front pipeline: cell coordinates, corner hashes and duplicate marking.
module nchs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  nchs_pkg::cfg_t      cfg,
  nchs_in_if.sink             in_ch,
  output logic                q_push,
  output nchs_pkg::entry_t    q_wdata,
  input  nchs_pkg::q_stat_t   q_stat
);
  import nchs_pkg::*;

  logic [FRONT_STAGES-1:0]              vld_r;
  logic [FRONT_STAGES-1:0]              vld_nxt;
  logic [2:0][63:0]                     prod_r;
  logic [2:0][COORD_W-1:0]              coord_r;
  logic [2:0][31:0]                     mul_r;
  logic [CORNER_COUNT-1:0][HASH_W-1:0]  hash_r;
  logic [CORNER_COUNT-1:0][HASH_W-1:0]  hash_c;
  logic [31:0]                          x_pair [2];
  logic [31:0]                          y_pair [2];
  logic [31:0]                          z_pair [2];
  logic [31:0]                          mask;
  logic [31:0]                          h_full;
  logic [CORNER_COUNT-1:0]              keep;
  logic                                 advance;
  logic                                 take;

  // The whole pipeline moves together; it holds only when the last stage
  // has a word and the queue has no room.
  assign advance     = !(vld_r[FRONT_STAGES-1] && q_stat.full);
  assign in_ch.ready = advance;
  assign take        = in_ch.valid && advance;

  assign vld_nxt = advance ? {vld_r[FRONT_STAGES-2:0], take} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r[0]  <= scale_pos(in_ch.pos_x, cfg.inv_cell);
      prod_r[1]  <= scale_pos(in_ch.pos_y, cfg.inv_cell);
      prod_r[2]  <= scale_pos(in_ch.pos_z, cfg.inv_cell);
      coord_r[0] <= floor_coord(prod_r[0]);
      coord_r[1] <= floor_coord(prod_r[1]);
      coord_r[2] <= floor_coord(prod_r[2]);
      mul_r[0]   <= coord_r[0] * cfg.prime_x;
      mul_r[1]   <= coord_r[1] * cfg.prime_y;
      mul_r[2]   <= coord_r[2] * cfg.prime_z;
      hash_r     <= hash_c;
    end
  end

  // (c+1)*p is c*p + p, so each axis needs one extra add.
  assign x_pair[0] = mul_r[0];
  assign x_pair[1] = mul_r[0] + cfg.prime_x;
  assign y_pair[0] = mul_r[1];
  assign y_pair[1] = mul_r[1] + cfg.prime_y;
  assign z_pair[0] = mul_r[2];
  assign z_pair[1] = mul_r[2] + cfg.prime_z;
  assign mask      = (32'd1 << cfg.log2) - 32'd1;

  always_comb begin
    h_full = '0;
    for (int i = 0; i < CORNER_COUNT; i++) begin
      h_full    = (x_pair[CORNER_DX[i]] ^ y_pair[CORNER_DY[i]] ^ z_pair[CORNER_DZ[i]]) & mask;
      hash_c[i] = h_full[HASH_W-1:0];
    end
  end

  // A corner is kept when no earlier corner has the same hash.
  always_comb begin
    keep = '1;
    for (int i = 1; i < CORNER_COUNT; i++) begin
      for (int j = 0; j < i; j++) begin
        if (hash_r[i] == hash_r[j]) begin
          keep[i] = 1'b0;
        end
      end
    end
  end

  assign q_push       = vld_r[FRONT_STAGES-1] && advance;
  assign q_wdata.hash = hash_r;
  assign q_wdata.keep = keep;

endmodule

// ----- hdl/nchs_queue.sv -----
// Short queue of hashed points between the front and back parts.
module nchs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nchs_pkg::entry_t   wdata,
  input  logic               pop,
  output nchs_pkg::entry_t   rdata,
  output nchs_pkg::q_stat_t  stat
);
  import nchs_pkg::*;

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hdl/nchs_back.sv -----
// Back part: walks the kept corners of one point and sends one word per hash.
module nchs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  nchs_pkg::entry_t   q_rdata,
  input  nchs_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  nchs_out_if.source         out_ch
);
  import nchs_pkg::*;

  logic [CORNER_COUNT-1:0][HASH_W-1:0] hash_r;
  logic [CORNER_COUNT-1:0]             rem_r;
  logic [CORNER_COUNT-1:0]             rem_nxt;
  logic                                cur_vld_r;
  logic                                cur_vld_nxt;
  logic                                out_vld_r;
  logic                                out_vld_nxt;
  logic [HASH_W-1:0]                   out_hash_r;
  logic                                out_last_r;
  logic [CORNER_W-1:0]                 idx;
  logic                                found;
  logic [CORNER_COUNT-1:0]             rem_clr;
  logic                                last;
  logic                                emit;

  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < CORNER_COUNT; i++) begin
      if (rem_r[i] && !found) begin
        idx   = CORNER_W'(i);
        found = 1'b1;
      end
    end
  end

  assign rem_clr = rem_r & ~(CORNER_COUNT'(1) << idx);
  assign last    = (rem_clr == '0);
  assign emit    = cur_vld_r && (!out_vld_r || out_ch.ready);
  // The next point is loaded in the cycle its predecessor sends its last word.
  assign q_pop   = !q_stat.empty && (!cur_vld_r || (emit && last));

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    rem_nxt     = rem_r;
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      rem_nxt     = q_rdata.keep;
    end else if (emit) begin
      rem_nxt = rem_clr;
      if (last) begin
        cur_vld_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hash_r <= q_rdata.hash;
    end
    if (emit) begin
      out_hash_r <= hash_r[idx];
      out_last_r <= last;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.cell_hash = out_hash_r;
  assign out_ch.is_last   = out_last_r;

endmodule

// ----- hdl/neighbor_cell_spatial_hash.sv -----
// Neighbor-cell spatial hash: point in, distinct hashes of its 2x2x2 cell block out.
//
// in_ch carries one point (pos_x, pos_y, pos_z, signed Q16.16) per word;
// out_ch carries one distinct cell hash per word, is_last set on the final
// hash of each point. Both use valid/ready; a word moves when both are high.
// Registers sit on an APB-style port: inverse cell size, table size log2 and
// the three axis primes, at byte addresses 0, 4, 8, 12 and 16.
//
// A point runs through a four-stage front pipeline (scale, floor, prime
// multiply, corner hash), is marked for duplicates and written into a
// four-entry queue. The back part sends the kept hashes one per cycle
// while the receiver keeps ready high. A point's first word passes the
// front stages, the queue and the back part's corner and output registers
// before it is presented. A point sends one word per distinct hash, one to
// eight words; the single result channel sets the sustained rate.
//
// Reset clears the pipeline, the queue and the output register, and loads
// the register defaults. When the receiver stalls, the output word holds,
// the queue fills, and in_ch.ready falls once the queue is full and a
// hashed point waits at the end of the front pipeline.
module neighbor_cell_spatial_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  nchs_in_if.sink                         in_ch,
  nchs_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nchs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nchs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nchs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import nchs_pkg::*;

  cfg_t    cfg;
  logic    q_push;
  logic    q_pop;
  entry_t  q_wdata;
  entry_t  q_rdata;
  q_stat_t q_stat;

  nchs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nchs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_stat  (q_stat)
  );

  nchs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  nchs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  // The back never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // The first corner of every point is always new, so each point sends a word.
  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_wdata.keep[0])
    else $error("first corner marked as duplicate");

  // A point accepted while everything was empty is pushed into the queue once it has passed the front pipeline.
  a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && q_stat.empty && (u_front.vld_r == '0)) |-> ##4 q_push)
    else $error("front pipeline lost a point");

endmodule

// ----- dv/nchs_hash_checker.sv -----
// Checker for the spatial hash: tracks the registers, predicts each point's hash words, compares.
`timescale 1ns / 100ps

module nchs_hash_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  nchs_in_if                              in_mon,
  nchs_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nchs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nchs_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [nchs_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              words_pending,
  output int                              points_seen,
  output int                              words_seen,
  output int                              single_points,
  output int                              full_points
);
  import nchs_pkg::*;

  typedef struct packed {
    logic [HASH_W-1:0] cell_hash;
    logic              is_last;
  } hash_word_t;

  // Neighbor corners as {dx, dy, dz}; element 0 is visited first.
  localparam logic [CORNER_COUNT-1:0][2:0] CORNER_OFS = {
    3'b010, 3'b110, 3'b111, 3'b011, 3'b001, 3'b101, 3'b100, 3'b000
  };

  hash_word_t        expected_hashes[$];
  logic [31:0]       inv_cell;
  logic [LOG2_W-1:0] tbl_log2;
  logic [31:0]       mul_x;
  logic [31:0]       mul_y;
  logic [31:0]       mul_z;

  int fail_n   = 0;
  int pend_n   = 0;
  int points_n = 0;
  int words_n  = 0;
  int single_n = 0;
  int full_n   = 0;

  assign fail_count    = fail_n;
  assign words_pending = pend_n;
  assign points_seen   = points_n;
  assign words_seen    = words_n;
  assign single_points = single_n;
  assign full_points   = full_n;

  // Signed position times unsigned reciprocal, less half a cell, floored and wrapped.
  function automatic logic [31:0] floor_cell(input logic [31:0] pos);
    logic [31:0] mag;
    logic [63:0] prod;
    mag  = pos[31] ? (~pos + 32'd1) : pos;
    prod = {32'd0, mag} * {32'd0, inv_cell};
    if (pos[31]) begin
      prod = ~prod + 64'd1;
    end
    prod = prod - 64'h0000_0000_8000_0000;
    return prod[63:32];
  endfunction

  function automatic void expand_neighbors(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz);
    logic [31:0] base_x;
    logic [31:0] base_y;
    logic [31:0] base_z;
    logic [31:0] mask;
    logic [31:0] h;
    logic [31:0] seen [CORNER_COUNT];
    logic [2:0]  ofs;
    hash_word_t  w;
    int          n;
    bit          dup;
    base_x = floor_cell(px);
    base_y = floor_cell(py);
    base_z = floor_cell(pz);
    mask   = (32'd1 << tbl_log2) - 32'd1;
    n      = 0;
    for (int i = 0; i < CORNER_COUNT; i++) begin
      ofs = CORNER_OFS[i];
      h = ((base_x + {31'd0, ofs[2]}) * mul_x) ^ ((base_y + {31'd0, ofs[1]}) * mul_y) ^
          ((base_z + {31'd0, ofs[0]}) * mul_z);
      h = h & mask;
      dup = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (seen[j] == h) begin
          dup = 1'b1;
        end
      end
      if (!dup) begin
        seen[n] = h;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      w.cell_hash = seen[i][HASH_W-1:0];
      w.is_last   = (i == n - 1);
      expected_hashes = {expected_hashes, w};
    end
    points_n++;
    if (n == 1) begin
      single_n++;
    end
    if (n == CORNER_COUNT) begin
      full_n++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    hash_word_t  want;
    logic [31:0] reg_val;
    bit          mapped;
    if (!rst_n) begin
      expected_hashes.delete();
      inv_cell = INV_CELL_RESET;
      tbl_log2 = LOG2_RESET;
      mul_x    = PRIME_X_RESET;
      mul_y    = PRIME_Y_RESET;
      mul_z    = PRIME_Z_RESET;
    end else begin
      // Results are checked before this edge's point is predicted, so a stray word
      // can never be matched against a point that was only just accepted.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hashes.size() == 0) begin
          fail_n++;
          $display("%0t: unexpected hash word: expected none, got hash %h last %b",
                   $time, out_mon.cell_hash, out_mon.is_last);
        end else begin
          want = expected_hashes.pop_front();
          words_n++;
          if (out_mon.cell_hash !== want.cell_hash || out_mon.is_last !== want.is_last) begin
            fail_n++;
            $display("%0t: hash word mismatch: expected hash %h last %b, got hash %h last %b",
                     $time, want.cell_hash, want.is_last, out_mon.cell_hash, out_mon.is_last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expand_neighbors(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z);
      end
      if (psel && penable && pready) begin
        mapped  = 1'b1;
        reg_val = 32'd0;
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_INV_CELL: reg_val = inv_cell;
          REG_LOG2:     reg_val = {27'd0, tbl_log2};
          REG_PRIME_X:  reg_val = mul_x;
          REG_PRIME_Y:  reg_val = mul_y;
          REG_PRIME_Z:  reg_val = mul_z;
          default:      mapped = 1'b0;
        endcase
        if (pwrite) begin
          case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
            REG_INV_CELL: inv_cell = pwdata;
            REG_LOG2:     tbl_log2 = pwdata[LOG2_W-1:0];
            REG_PRIME_X:  mul_x = pwdata;
            REG_PRIME_Y:  mul_y = pwdata;
            REG_PRIME_Z:  mul_z = pwdata;
            default:      ;
          endcase
        end else if (mapped && prdata !== reg_val) begin
          fail_n++;
          $display("%0t: register read mismatch at %h: expected %h, got %h",
                   $time, paddr, reg_val, prdata);
        end
      end
    end
    pend_n = expected_hashes.size();
  end

endmodule

// ----- dv/tb_neighbor_cell_spatial_hash.sv -----
// Testbench top: drives points and register writes into the spatial hash and gives the verdict.
`timescale 1ns / 100ps

module tb_neighbor_cell_spatial_hash;
  import nchs_pkg::*;

  localparam int unsigned CLK_HALF_NS      = 5;
  localparam int unsigned LIMIT_NS         = 5_000_000;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PRESSURE_POINTS  = 24;
  localparam int unsigned RANDOM_PHASES    = 10;
  localparam int unsigned POINTS_PER_PHASE = 27;
  localparam logic [2:0]  IDX_UNMAPPED_LO  = 3'd5;
  localparam logic [2:0]  IDX_UNMAPPED_HI  = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int words_pending;
  int points_seen;
  int words_seen;
  int single_points;
  int full_points;
  int settings_n;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req_n = 0;

  nchs_in_if  in_ch ();
  nchs_out_if out_ch ();

  neighbor_cell_spatial_hash u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nchs_hash_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .points_seen   (points_seen),
    .words_seen    (words_seen),
    .single_points (single_points),
    .full_points   (full_points)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("neighbor_cell_spatial_hash test failed");
    $finish;
  end

  // A hold request parks ready low for a long stretch counted here, so the queue fills.
  initial begin : receiver
    int hold_done_n;
    hold_done_n  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req_n != hold_done_n) begin
        hold_done_n = hold_req_n;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 81 : (mode == IDLE_BOTH) ? 14 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 81 : (mode == IDLE_BOTH) ? 14 : 0;
  endfunction

  // Mostly points within a few cells of the origin on both sides, some anywhere.
  function automatic logic [31:0] rand_pos();
    logic [31:0] v;
    if ($urandom_range(3) == 0) begin
      v = $urandom;
    end else begin
      v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_prime();
    logic [31:0] v;
    case ($urandom_range(7))
      0:       v = 32'd0;
      1:       v = 32'd1;
      2:       v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word moved,
  // with valid still high so back-to-back points need no gap.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.pos_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup phase, access phase until pready, then psel and penable low before the next transfer.
  task automatic cfg_access(input bit wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_all();
    cfg_access(1'b0, REG_INV_CELL, 32'd0);
    cfg_access(1'b0, REG_LOG2, 32'd0);
    cfg_access(1'b0, REG_PRIME_X, 32'd0);
    cfg_access(1'b0, REG_PRIME_Y, 32'd0);
    cfg_access(1'b0, REG_PRIME_Z, 32'd0);
  endtask

  task automatic apply_settings(input logic [31:0] inv, input logic [31:0] log2_raw,
                                input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz);
    cfg_access(1'b1, REG_INV_CELL, inv);
    cfg_access(1'b1, REG_LOG2, log2_raw);
    cfg_access(1'b1, REG_PRIME_X, px);
    cfg_access(1'b1, REG_PRIME_Y, py);
    cfg_access(1'b1, REG_PRIME_Z, pz);
    read_all();
    settings_n++;
  endtask

  initial begin : stimulus
    logic [31:0] inv;
    logic [31:0] log2_raw;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    settings_n  = 1;
    set_idle(IDLE_NONE);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults after reset: unit cells, 16-bit table.
    read_all();
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Exactly on and just below the half-cell boundaries, both signs.
    send_point(32'h0000_8000, 32'h0000_7FFF, 32'h0001_8000);
    send_point(32'hFFFF_8000, 32'hFFFF_7FFF, 32'h1234_5678);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    // Largest reciprocal and widest table: products and coordinates wrap.
    drain();
    apply_settings(32'hFFFF_FFFF, 32'd31, PRIME_X_RESET, PRIME_Y_RESET, PRIME_Z_RESET);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001);

    // Zero reciprocal puts every point at cell minus one, whose upper corner wraps to zero.
    drain();
    apply_settings(32'd0, 32'd20, PRIME_X_RESET, PRIME_Y_RESET, PRIME_Z_RESET);
    send_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);

    // Zero mask width, written with junk above the field: a single hash per point.
    drain();
    apply_settings(INV_CELL_RESET, 32'hFFFF_FFE0, PRIME_X_RESET, PRIME_Y_RESET, PRIME_Z_RESET);
    send_point(32'h0003_4000, 32'hFFF0_0000, 32'h0000_1000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

    // Tiny table gives duplicates; writes past the last register must change nothing.
    drain();
    apply_settings(INV_CELL_RESET, 32'hABCD_EF03, PRIME_X_RESET, PRIME_Y_RESET, PRIME_Z_RESET);
    cfg_access(1'b1, IDX_UNMAPPED_LO, 32'hFFFF_FFFF);
    cfg_access(1'b1, IDX_UNMAPPED_HI, 32'h0000_0000);
    read_all();
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'hFFFE_0000, 32'h0005_8000, 32'h7FFF_0000);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000);

    // A zero x multiplier folds corners that differ only in x.
    drain();
    apply_settings(INV_CELL_RESET, 32'd31, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0002_0000, 32'hFFFD_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);

    drain();
    apply_settings(INV_CELL_RESET, 32'd31, 32'd0, 32'd0, 32'd0);
    send_point(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);

    // Unit multipliers: the hash is cx ^ cy ^ cz, so many corners coincide.
    drain();
    apply_settings(INV_CELL_RESET, 32'd31, 32'd1, 32'd1, 32'd1);
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_point(32'h0001_8000, 32'h0002_8000, 32'h0003_8000);

    // Long receiver hold while points keep coming: the queue fills and input stalls.
    drain();
    apply_settings(INV_CELL_RESET, LOG2_RESET, PRIME_X_RESET, PRIME_Y_RESET, PRIME_Z_RESET);
    @(posedge clk);
    hold_req_n++;
    @(negedge clk);
    repeat (PRESSURE_POINTS) send_point(rand_pos(), rand_pos(), rand_pos());

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case ($urandom_range(2))
        0:       inv = $urandom;
        1:       inv = $urandom_range(32'h0002_0000);
        default: inv = INV_CELL_RESET;
      endcase
      // Small tables most of the time, so duplicate corners show up often.
      log2_raw = $urandom;
      log2_raw[LOG2_W-1:0] = LOG2_W'(($urandom_range(2) == 0) ? $urandom_range(31) :
                                                               $urandom_range(4));
      apply_settings(inv, log2_raw, rand_prime(), rand_prime(), rand_prime());
      set_idle(idle_mode_t'(p % 4));
      repeat (POINTS_PER_PHASE) send_point(rand_pos(), rand_pos(), rand_pos());
    end
    drain();

    $display("Covered %0d points and %0d hash words under %0d register settings,",
             points_seen, words_seen, settings_n);
    $display("with %0d points folded to a single hash and %0d keeping all eight corners.",
             single_points, full_points);
    if (fail_count == 0) begin
      $display("neighbor_cell_spatial_hash test passed");
    end else begin
      $display("neighbor_cell_spatial_hash test failed");
    end
    $finish;
  end

endmodule
